// ===== design/tsps_pkg.sv =====
// Shared types and constants for the two-set pair sum search unit.
package tsps_pkg;

  localparam int VAL_W = 32;
  localparam int KEY_W = VAL_W + 1;

  // Register indexes (byte address bit 2 and up)
  localparam logic REG_TARGET_SUM = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] second_value;
  } result_t;

endpackage

// ===== design/tsps_ram.sv =====
// Single-write, single-read element store with registered read data.
module tsps_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tsps_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [tsps_pkg::VAL_W-1:0] rdata
);
  import tsps_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tsps_ctrl.sv =====
// Sequencer: sorted insert on load, binary search with one shared signed compare.
module tsps_ctrl #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [tsps_pkg::VAL_W-1:0]  in_value,
  input  logic                        in_last,
  input  logic [tsps_pkg::VAL_W-1:0]  target_sum,
  output tsps_pkg::result_t           result
);
  import tsps_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

  state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             sorted_r, sorted_nxt;
  logic             hit_r, hit_nxt;
  logic [VAL_W-1:0] hit_first_r, hit_first_nxt;
  logic [VAL_W-1:0] hit_second_r, hit_second_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] second_r, second_nxt;
  logic             last_r, last_nxt;
  logic [AW-1:0]    j_r, j_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [CW-1:0]    mid_r, mid_nxt;
  result_t          res_r, res_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rdata;

  logic [CW-1:0]    cnt_eff;
  logic             accept;
  logic             has_room;
  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid_w;
  logic             probe_lt;
  logic             probe_eq;
  logic             probe_gt;

  tsps_ram #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared signed compare: store entry against key
  assign probe_lt = $signed({rdata[VAL_W-1], rdata}) < $signed(key_r);
  assign probe_eq = {rdata[VAL_W-1], rdata} == key_r;
  assign probe_gt = !probe_lt && !probe_eq;

  assign accept   = start && (state_r == ST_IDLE);
  assign cnt_eff  = sorted_r ? '0 : cnt_r;
  assign has_room = cnt_eff < MAX_C;
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w    = mid_sum[CW:1];
  assign busy     = state_r != ST_IDLE;
  assign result   = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_mode) begin
            state_nxt = hit_r ? ST_DONE : ST_SRCH_RD;
          end else if (has_room) begin
            state_nxt = ST_INS_RD;
          end
        end
      end
      ST_INS_RD:   state_nxt = (j_r == '0) ? ST_IDLE : ST_INS_CMP;
      ST_INS_CMP:  state_nxt = probe_gt ? ST_INS_RD : ST_IDLE;
      ST_SRCH_RD:  state_nxt = (lo_r >= hi_r) ? ST_DONE : ST_SRCH_CMP;
      ST_SRCH_CMP: state_nxt = probe_eq ? ST_DONE : ST_SRCH_RD;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    sorted_nxt     = sorted_r;
    hit_nxt        = hit_r;
    hit_first_nxt  = hit_first_r;
    hit_second_nxt = hit_second_r;
    key_nxt        = key_r;
    second_nxt     = second_r;
    last_nxt       = last_r;
    j_nxt          = j_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    res_nxt        = '0;
    we             = 1'b0;
    waddr          = j_r;
    wdata          = key_r[VAL_W-1:0];
    raddr          = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_mode) begin
            if (sorted_r) begin
              hit_nxt        = 1'b0;
              hit_first_nxt  = '0;
              hit_second_nxt = '0;
            end
            sorted_nxt = in_last;
            cnt_nxt    = cnt_eff;
            if (has_room) begin
              cnt_nxt = cnt_eff + 1'b1;
              j_nxt   = cnt_eff[AW-1:0];
              key_nxt = {in_value[VAL_W-1], in_value};
            end
          end else begin
            sorted_nxt = 1'b1;
            last_nxt   = in_last;
            second_nxt = in_value;
            key_nxt    = {target_sum[VAL_W-1], target_sum} - {in_value[VAL_W-1], in_value};
            lo_nxt     = '0;
            hi_nxt     = cnt_r;
          end
        end
      end
      ST_INS_RD: begin
        raddr = j_r - 1'b1;
        if (j_r == '0) begin
          we    = 1'b1;
          waddr = '0;
        end
      end
      ST_INS_CMP: begin
        we = 1'b1;
        if (probe_gt) begin
          wdata = rdata;
          j_nxt = j_r - 1'b1;
        end
      end
      ST_SRCH_RD: begin
        raddr   = mid_w[AW-1:0];
        mid_nxt = mid_w;
      end
      ST_SRCH_CMP: begin
        if (probe_eq) begin
          hit_nxt        = 1'b1;
          hit_first_nxt  = key_r[VAL_W-1:0];
          hit_second_nxt = second_r;
        end else if (probe_lt) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
      end
      ST_DONE: begin
        if (last_r) begin
          res_nxt.valid        = 1'b1;
          res_nxt.found        = hit_r;
          res_nxt.first_value  = hit_first_r;
          res_nxt.second_value = hit_second_r;
          hit_nxt              = 1'b0;
          hit_first_nxt        = '0;
          hit_second_nxt       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      sorted_r     <= 1'b0;
      hit_r        <= 1'b0;
      hit_first_r  <= '0;
      hit_second_r <= '0;
      res_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      sorted_r     <= sorted_nxt;
      hit_r        <= hit_nxt;
      hit_first_r  <= hit_first_nxt;
      hit_second_r <= hit_second_nxt;
      res_r        <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    second_r <= second_nxt;
    last_r   <= last_nxt;
    j_r      <= j_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
  end

endmodule

// ===== design/two_set_pair_sum_search_unit.sv =====
// Top level: pair sum search over two sets with an APB target register.
//
// Usage: write target_sum at byte address 0 over APB while idle. Present
// transactions with start while busy is low; in_mode 0 loads a first-set
// value, in_mode 1 searches target_sum - in_value in the first set.
// in_last closes the set. A second-set transaction with in_last set yields
// one result: out_valid is high for exactly one cycle with out_found and
// the pair (zero when nothing matched).
// A first-set load keeps the store sorted by insertion, shifting larger
// entries up one place at a time; it does no work when the store is full.
// A second-set search is a binary search with p <= ceil(log2(n+1)) probes
// of the store, stopping early on a hit and skipped when a hit is already
// held; the single memory read port sets the pace of the probes. out_valid
// is high in the first cycle after busy drops. Reset clears count, flags and
// hit latch; no clearing pass is run, the store is only read below the count.
// The receiver cannot stall.
module two_set_pair_sum_search_unit #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [tsps_pkg::VAL_W-1:0] in_value,
  input  logic                       in_last,
  output logic                       out_valid,
  output logic                       out_found,
  output logic [tsps_pkg::VAL_W-1:0] out_first_value,
  output logic [tsps_pkg::VAL_W-1:0] out_second_value
);
  import tsps_pkg::*;

  logic [VAL_W-1:0] target_r;
  logic             cfg_wr;
  result_t          result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TARGET_SUM) ? target_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr && (paddr[2] == REG_TARGET_SUM)) begin
      target_r <= pwdata;
    end
  end

  tsps_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .in_last    (in_last),
    .target_sum (target_r),
    .result     (result)
  );

  assign out_valid        = result.valid;
  assign out_found        = result.found;
  assign out_first_value  = result.first_value;
  assign out_second_value = result.second_value;

`ifndef SYNTHESIS
  a_search_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |=> busy)
    else $error("search transaction did not start the sequencer");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_first_value == '0 && out_second_value == '0))
    else $error("miss result carries nonzero pair");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// ===== dv/two_set_pair_sum_search_unit_test.sv =====
// Self-checking testbench for the two-set pair sum search unit.
`timescale 1ns / 1ps

module two_set_pair_sum_search_unit_test;

  localparam int STORE_DEPTH    = 64;
  localparam int SETTLE_CYCLES  = 160;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_TXNS     = 85;

  typedef struct packed {
    logic        mode;
    logic [31:0] value;
    logic        last;
  } search_txn_t;

  typedef struct packed {
    logic        found;
    logic [31:0] first_value;
    logic [31:0] second_value;
  } pair_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        in_mode = 1'b0;
  logic [31:0] in_value = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_found;
  logic [31:0] out_first_value;
  logic [31:0] out_second_value;

  search_txn_t  pending_txns[$];
  pair_result_t pending_pairs[$];

  // predictor state
  logic signed [31:0] target_sum = '0;
  logic [31:0]        held_vals[STORE_DEPTH];
  int unsigned        held_cnt = 0;
  bit                 set_closed = 0;
  bit                 hit_valid = 0;
  logic [31:0]        hit_first = '0;
  logic [31:0]        hit_second = '0;

  int errors = 0;
  int n_generated = 0;
  int n_directed = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_hits = 0;
  int n_settings = 1;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;

  two_set_pair_sum_search_unit #(
    .MAX_ELEMENTS(STORE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value)
  );

  always #6 clk = ~clk;

  function automatic void predict_pair(search_txn_t t);
    longint comp;
    if (!t.mode) begin
      if (set_closed) begin
        held_cnt   = 0;
        set_closed = 0;
        hit_valid  = 0;
        hit_first  = '0;
        hit_second = '0;
      end
      if (held_cnt < STORE_DEPTH) begin
        held_vals[held_cnt] = t.value;
        held_cnt++;
      end
      if (t.last) set_closed = 1;
    end else begin
      set_closed = 1;
      if (!hit_valid) begin
        comp = longint'(target_sum) - longint'($signed(t.value));
        for (int i = 0; i < held_cnt; i++)
          if (longint'($signed(held_vals[i])) == comp) hit_valid = 1;
        if (hit_valid) begin
          hit_first  = comp[31:0];
          hit_second = t.value;
        end
      end
      if (t.last) begin
        pending_pairs.push_back('{hit_valid, hit_first, hit_second});
        hit_valid  = 0;
        hit_first  = '0;
        hit_second = '0;
      end
    end
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 2);
      1: return 32'h7fff_ffff - $urandom_range(0, 2);
      2: return $urandom_range(0, 8) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_txn(input logic mode, input logic [31:0] value, input logic last);
    pending_txns.push_back('{mode, value, last});
    n_generated++;
  endtask

  // One first set followed by zero or more second sets, with some broken endings.
  task automatic queue_problem(input bit force_full);
    int          n;
    int          m;
    int          rounds;
    bit          open_end;
    bit          cut;
    longint      b;
    logic [31:0] v;
    logic [31:0] vals[$];
    if (force_full) n = 66;
    else if ($urandom_range(0, 15) == 0) n = $urandom_range(60, 68);
    else n = $urandom_range(1, 10);
    open_end = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < n; i++) begin
      v = pick_value();
      vals.push_back(v);
      push_txn(1'b0, v, (i == n - 1) && !open_end);
    end
    rounds = ($urandom_range(0, 5) == 0) ? 2 : 1;
    if ($urandom_range(0, 9) == 0) rounds = 0;
    for (int r = 0; r < rounds; r++) begin
      m   = $urandom_range(1, 8);
      cut = ($urandom_range(0, 9) == 0);
      for (int j = 0; j < m; j++) begin
        v = pick_value();
        if ($urandom_range(0, 2) == 0) begin
          b = longint'(target_sum) - longint'($signed(vals[$urandom_range(0, n - 1)]));
          if (b >= -64'sd2147483648 && b <= 64'sd2147483647) v = b[31:0];
        end
        push_txn(1'b1, v, (j == m - 1) && !cut);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_txns.size() != 0 || pending_pairs.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_target(input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {tsps_pkg::REG_TARGET_SUM, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      errors++;
      $display("%0t: target_sum readback expected %h actual %h", $time, value, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    target_sum = value;
    n_settings++;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (!rst_n || pending_txns.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else begin
      start    <= 1'b1;
      in_mode  <= pending_txns[0].mode;
      in_value <= pending_txns[0].value;
      in_last  <= pending_txns[0].last;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      end
    end
  end

  // monitor, acceptance and watchdog
  always @(posedge clk) begin
    pair_result_t exp_r;
    bit           active;
    active = 0;
    if (rst_n) begin
      if (out_valid) begin
        active = 1;
        n_results++;
        if (out_found === 1'b1) n_hits++;
        if (pending_pairs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual found=%b first=%h second=%h",
                   $time, out_found, out_first_value, out_second_value);
        end else begin
          exp_r = pending_pairs.pop_front();
          check_field("found", {31'b0, exp_r.found}, {31'b0, out_found});
          check_field("first_value", exp_r.first_value, out_first_value);
          check_field("second_value", exp_r.second_value, out_second_value);
        end
      end
      if (start && !busy && pending_txns.size() != 0) begin
        active = 1;
        predict_pair(pending_txns.pop_front());
        n_accepted++;
      end
      if (psel && penable && pready) active = 1;
    end
    idle_cycles = active ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d transactions and %0d results outstanding",
               $time, pending_txns.size(), pending_pairs.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [31:0] targets[6];
    int          goal;
    targets = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, $urandom(), 32'h0, $urandom()};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty first set, closed implicitly by the search
    push_txn(1'b1, 32'd5, 1'b0);
    push_txn(1'b1, 32'h8000_0000, 1'b1);
    // extremes in the first set
    push_txn(1'b0, 32'h8000_0000, 1'b0);
    push_txn(1'b0, 32'h7fff_ffff, 1'b0);
    push_txn(1'b0, 32'h0, 1'b0);
    push_txn(1'b0, 32'hffff_ffff, 1'b0);
    push_txn(1'b0, 32'd7, 1'b1);
    // earliest hit kept; a later complement beyond 32 bits is not searched
    push_txn(1'b1, 32'd1, 1'b0);
    push_txn(1'b1, 32'h8000_0000, 1'b0);
    push_txn(1'b1, 32'hffff_fff9, 1'b1);
    // store kept across second sets
    push_txn(1'b1, 32'h7fff_ffff, 1'b1);
    push_txn(1'b1, 32'h8000_0001, 1'b1);
    // new first set with duplicates, searched before its last mark
    push_txn(1'b0, 32'd3, 1'b0);
    push_txn(1'b0, 32'd3, 1'b0);
    push_txn(1'b1, 32'hffff_fffd, 1'b0);
    push_txn(1'b1, 32'h0, 1'b0);
    // new first set drops the pending hit
    push_txn(1'b0, 32'd9, 1'b1);
    push_txn(1'b1, 32'hffff_fff7, 1'b1);
    n_directed = n_generated;
    wait_idle();

    foreach (targets[p]) begin
      write_target(targets[p]);
      goal = n_generated + PHASE_TXNS;
      queue_problem(p == 0);
      while (n_generated < goal) queue_problem(1'b0);
      wait_idle();
    end

    $display("Ran %0d transactions (%0d directed) under %0d target_sum settings",
             n_accepted, n_directed, n_settings);
    $display("Checked %0d results, %0d of them with a pair found", n_results, n_hits);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
